// ===== hdl/x86dec_pkg.sv =====
`timescale 1ns / 1ps

package x86dec_pkg;

  // One instruction window and its address
  typedef struct packed {
    logic [63:0] bytes_low;
    logic [63:0] bytes_high;
    logic [4:0]  avail_count;
    logic [63:0] insn_address;
  } in_t;

  // One decoded instruction
  typedef struct packed {
    logic               valid_res;
    logic [4:0]         length;
    logic [5:0]         form_class;
    logic [3:0]         variant;
    logic [1:0]         operand_size;
    logic [4:0]         reg_field;
    logic [1:0]         rm_kind;
    logic [4:0]         rm_base;
    logic [4:0]         index_reg;
    logic [1:0]         scale_log2;
    logic signed [31:0] displacement;
    logic [63:0]        immediate;
  } out_t;

  // Pipeline depth from an accepted start to the result strobe
  localparam int unsigned LATENCY = 4;

endpackage

// ===== hdl/x86_64_instruction_decoder.sv =====
`timescale 1ns / 1ps

// x86-64 instruction decoder. Pulse start with a window of up to 16 bytes,
// the count of valid bytes and the instruction address; busy stays low, so
// a new transaction may start in every cycle. Each transaction gives exactly
// one result, shown on out_data for one cycle with out_valid high. The four
// register stages are prefix scan, opcode decode, ModRM/SIB/displacement
// decode, and immediate extraction with the 64-bit branch target add. The
// receiver cannot stall the result. A result with valid_res low ran out of
// bytes and has every other field zero.
module x86_64_instruction_decoder #(
  parameter int unsigned WINDOW_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  x86dec_pkg::in_t   in_data,
  output logic              out_valid,
  output x86dec_pkg::out_t  out_data
);

  typedef enum logic [2:0] {IK_NONE, IK_ZX, IK_SX, IK_ONE, IK_CONST} imm_kind_t;
  typedef enum logic [1:0] {GRP_NONE, GRP_FEFF, GRP_F6F7} grp_t;
  typedef enum logic [1:0] {RS_NONE, RS_OPC, RS_MODRM} reg_src_t;

  typedef struct packed {
    logic [127:0] win;
    logic [63:0]  addr;
    logic [4:0]   cnt;
    logic [4:0]   pos;
    logic         rex, w, r, x, b;
  } s1_t;

  typedef struct packed {
    logic [5:0]  cls;
    logic [3:0]  var_code;
    logic [1:0]  osz;
    reg_src_t    rs;
    logic [4:0]  regf;
    logic        rbf;
    logic        has_m;
    logic        mbf;
    logic        var_m;
    grp_t        grp;
    logic [7:0]  opc;
    logic [1:0]  oplen;
    imm_kind_t   ik;
    logic [3:0]  ilen;
    logic        br;
    logic [15:0] iconst;
  } dec_t;

  typedef struct packed {
    logic [127:0] win;
    logic [63:0]  addr;
    logic         ok;
    logic [4:0]   endp;
    logic [5:0]   ipos;
    logic [5:0]   cls;
    logic [3:0]   var_code;
    logic [1:0]   osz;
    logic [4:0]   regf;
    logic [1:0]   rm_kind;
    logic [4:0]   rm_base;
    logic [4:0]   idx;
    logic [1:0]   scale;
    logic [31:0]  disp;
    imm_kind_t    ik;
    logic [3:0]   ilen;
    logic         br;
    logic [15:0]  iconst;
  } s3_t;

  function automatic logic [7:0] byte_at(input logic [127:0] win, input logic [5:0] p);
    byte_at = win[p[3:0]*8 +: 8];
  endfunction

  function automatic logic [4:0] regnum(input logic [2:0] x3, input logic ext,
                                        input logic bytef, input logic rex);
    if (bytef && !rex && x3[2]) regnum = {2'b10, 1'b0, x3[1:0]};
    else regnum = {1'b0, ext, x3};
  endfunction

  assign busy = 1'b0;

  // ---------------- stage 1: prefix scan ----------------
  logic              v1_r, v2_r, v3_r;
  s1_t               s1_r, s1_nxt;
  s1_t               s2b_r;
  dec_t              s2_r, s2_nxt;
  s3_t               s3_r, s3_nxt;
  x86dec_pkg::out_t  out_r, out_nxt;
  logic              vo_r;

  always_comb begin
    logic [127:0] win;
    logic [4:0]   cnt;
    logic [15:0]  stop;
    logic [4:0]   pos;
    logic [7:0]   pb, pv;
    win = {in_data.bytes_high, in_data.bytes_low};
    cnt = (in_data.avail_count > 5'(WINDOW_BYTES)) ? 5'(WINDOW_BYTES) : in_data.avail_count;
    for (int i = 0; i < 16; i++) begin
      pb = win[i*8 +: 8];
      stop[i] = !((pb[7:4] == 4'h4 || pb == 8'h66 || pb == 8'h67 || pb == 8'hF2 ||
                   pb == 8'hF3) && (5'(i) < cnt));
    end
    // find the first byte that ends the prefix run
    pos = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (stop[i]) pos = 5'(i);
    end
    // the last prefix decides REX: a legacy prefix after it cancels it
    pv = (pos != 5'd0) ? win[(4'(pos - 5'd1))*8 +: 8] : 8'h00;
    s1_nxt.win  = win;
    s1_nxt.addr = in_data.insn_address;
    s1_nxt.cnt  = cnt;
    s1_nxt.pos  = pos;
    s1_nxt.rex  = (pos != 5'd0) && (pv[7:4] == 4'h4);
    s1_nxt.w    = s1_nxt.rex && pv[3];
    s1_nxt.r    = s1_nxt.rex && pv[2];
    s1_nxt.x    = s1_nxt.rex && pv[1];
    s1_nxt.b    = s1_nxt.rex && pv[0];
  end

  // ---------------- stage 2: opcode decode ----------------
  always_comb begin
    logic [7:0] opc, k;
    logic       bf;
    opc = byte_at(s1_r.win, {1'b0, s1_r.pos});
    k   = byte_at(s1_r.win, {1'b0, s1_r.pos} + 6'd1);
    bf  = !opc[0];
    s2_nxt = '0;
    s2_nxt.osz = s1_r.w ? 2'd3 : 2'd2;
    s2_nxt.opc = opc;
    s2_nxt.oplen = 2'd1;
    s2_nxt.ik = IK_NONE;
    s2_nxt.grp = GRP_NONE;
    s2_nxt.rs = RS_NONE;
    case (opc)
      8'h90: begin
        if (s1_r.b) begin
          s2_nxt.cls = 6'd46; s2_nxt.regf = 5'd8;
        end else s2_nxt.cls = 6'd1;
      end
      8'hCC: s2_nxt.cls = 6'd2;
      8'hC3: begin s2_nxt.cls = 6'd3; s2_nxt.osz = 2'd3; end
      8'hC9: begin s2_nxt.cls = 6'd4; s2_nxt.osz = 2'd3; end
      8'h98: s2_nxt.cls = 6'd5;
      8'h99: s2_nxt.cls = 6'd6;
      8'hF4: s2_nxt.cls = 6'd7;
      8'hCD: begin s2_nxt.cls = 6'd8; s2_nxt.ik = IK_ZX; s2_nxt.ilen = 4'd1; end
      8'hC2: begin
        s2_nxt.cls = 6'd22; s2_nxt.osz = 2'd3; s2_nxt.ik = IK_ZX; s2_nxt.ilen = 4'd2;
      end
      8'h68: begin
        s2_nxt.cls = 6'd19; s2_nxt.osz = 2'd3; s2_nxt.ik = IK_ZX; s2_nxt.ilen = 4'd4;
      end
      8'h6A: begin
        s2_nxt.cls = 6'd19; s2_nxt.osz = 2'd3; s2_nxt.ik = IK_SX; s2_nxt.ilen = 4'd1;
      end
      8'hEB: begin
        s2_nxt.cls = 6'd20; s2_nxt.osz = 2'd3; s2_nxt.br = 1'b1;
        s2_nxt.ik = IK_SX; s2_nxt.ilen = 4'd1;
      end
      8'hE9, 8'hE8: begin
        s2_nxt.cls = (opc == 8'hE8) ? 6'd21 : 6'd20; s2_nxt.osz = 2'd3; s2_nxt.br = 1'b1;
        s2_nxt.ik = IK_SX; s2_nxt.ilen = 4'd4;
      end
      8'h8D, 8'h63: begin
        s2_nxt.cls = (opc == 8'h63) ? 6'd26 : 6'd23;
        if (opc == 8'h63) s2_nxt.osz = 2'd3;
        s2_nxt.has_m = 1'b1; s2_nxt.rs = RS_MODRM;
      end
      8'hC6: begin
        s2_nxt.cls = 6'd27; s2_nxt.osz = 2'd0; s2_nxt.has_m = 1'b1; s2_nxt.mbf = 1'b1;
        s2_nxt.ik = IK_ZX; s2_nxt.ilen = 4'd1;
      end
      8'hC7: begin
        s2_nxt.cls = 6'd27; s2_nxt.has_m = 1'b1; s2_nxt.ik = IK_ZX; s2_nxt.ilen = 4'd4;
      end
      8'h0F: begin
        s2_nxt.oplen = 2'd2;
        if (k == 8'h05) s2_nxt.cls = 6'd9;
        else if (k == 8'h31) s2_nxt.cls = 6'd10;
        else if (k == 8'h1F) begin
          s2_nxt.cls = 6'd11; s2_nxt.has_m = 1'b1;
        end else if (k[7:4] == 4'h8) begin
          s2_nxt.cls = 6'd12; s2_nxt.var_code = k[3:0]; s2_nxt.osz = 2'd3;
          s2_nxt.br = 1'b1; s2_nxt.ik = IK_SX; s2_nxt.ilen = 4'd4;
        end else if (k[7:4] == 4'h9) begin
          s2_nxt.cls = 6'd13; s2_nxt.var_code = k[3:0]; s2_nxt.osz = 2'd0;
          s2_nxt.has_m = 1'b1; s2_nxt.mbf = 1'b1;
        end else if (k == 8'hB6 || k == 8'hB7 || k == 8'hBE || k == 8'hBF) begin
          s2_nxt.cls = k[3] ? 6'd15 : 6'd14; s2_nxt.var_code = {3'd0, k[0]};
          s2_nxt.has_m = 1'b1; s2_nxt.mbf = !k[0]; s2_nxt.rs = RS_MODRM;
        end else if (k == 8'hAF) begin
          s2_nxt.cls = 6'd16; s2_nxt.has_m = 1'b1; s2_nxt.rs = RS_MODRM;
        end else begin
          s2_nxt.ik = IK_CONST; s2_nxt.iconst = {8'h0F, k};
        end
      end
      default: begin
        if (opc[7:4] == 4'h5) begin
          s2_nxt.cls = opc[3] ? 6'd18 : 6'd17; s2_nxt.osz = 2'd3;
          s2_nxt.regf = regnum(opc[2:0], s1_r.b, 1'b0, s1_r.rex);
        end else if (opc[7:4] == 4'h7) begin
          s2_nxt.cls = 6'd12; s2_nxt.var_code = opc[3:0]; s2_nxt.osz = 2'd3;
          s2_nxt.br = 1'b1; s2_nxt.ik = IK_SX; s2_nxt.ilen = 4'd1;
        end else if (opc[7:2] == 6'b100010) begin
          s2_nxt.cls = opc[1] ? 6'd25 : 6'd24;
          if (bf) s2_nxt.osz = 2'd0;
          s2_nxt.has_m = 1'b1; s2_nxt.mbf = bf; s2_nxt.rs = RS_MODRM; s2_nxt.rbf = bf;
        end else if (opc[7:4] == 4'hB) begin
          s2_nxt.cls = 6'd28;
          s2_nxt.regf = regnum(opc[2:0], s1_r.b, !opc[3], s1_r.rex);
          s2_nxt.ik = IK_ZX;
          if (!opc[3]) begin
            s2_nxt.osz = 2'd0; s2_nxt.ilen = 4'd1;
          end else s2_nxt.ilen = s1_r.w ? 4'd8 : 4'd4;
        end else if (opc < 8'h40 && !opc[2]) begin
          s2_nxt.cls = opc[1] ? 6'd30 : 6'd29; s2_nxt.var_code = {1'b0, opc[5:3]};
          if (bf) s2_nxt.osz = 2'd0;
          s2_nxt.has_m = 1'b1; s2_nxt.mbf = bf; s2_nxt.rs = RS_MODRM; s2_nxt.rbf = bf;
        end else if (opc == 8'h80 || opc == 8'h81 || opc == 8'h83) begin
          s2_nxt.cls = 6'd31;
          if (opc == 8'h80) s2_nxt.osz = 2'd0;
          s2_nxt.has_m = 1'b1; s2_nxt.mbf = (opc == 8'h80); s2_nxt.var_m = 1'b1;
          s2_nxt.ik = (opc == 8'h83) ? IK_SX : IK_ZX;
          s2_nxt.ilen = (opc == 8'h81) ? 4'd4 : 4'd1;
        end else if (opc == 8'hFE || opc == 8'hFF) begin
          s2_nxt.has_m = 1'b1; s2_nxt.mbf = bf; s2_nxt.var_m = 1'b1; s2_nxt.grp = GRP_FEFF;
        end else if (opc == 8'hF6 || opc == 8'hF7) begin
          if (bf) s2_nxt.osz = 2'd0;
          s2_nxt.has_m = 1'b1; s2_nxt.mbf = bf; s2_nxt.var_m = 1'b1; s2_nxt.grp = GRP_F6F7;
        end else if (opc == 8'hC0 || opc == 8'hC1 || opc[7:2] == 6'b110100) begin
          if (bf) s2_nxt.osz = 2'd0;
          s2_nxt.has_m = 1'b1; s2_nxt.mbf = bf; s2_nxt.var_m = 1'b1;
          if (opc[7:4] == 4'hC) begin
            s2_nxt.cls = 6'd42; s2_nxt.ik = IK_ZX; s2_nxt.ilen = 4'd1;
          end else if (!opc[1]) begin
            s2_nxt.cls = 6'd43; s2_nxt.ik = IK_ONE;
          end else s2_nxt.cls = 6'd44;
        end else if (opc == 8'h86 || opc == 8'h87) begin
          s2_nxt.cls = 6'd45;
          if (bf) s2_nxt.osz = 2'd0;
          s2_nxt.has_m = 1'b1; s2_nxt.mbf = bf; s2_nxt.rs = RS_MODRM; s2_nxt.rbf = bf;
        end else if (opc[7:3] == 5'b10010) begin
          s2_nxt.cls = 6'd46; s2_nxt.regf = regnum(opc[2:0], s1_r.b, 1'b0, s1_r.rex);
        end else if (opc == 8'h69 || opc == 8'h6B) begin
          s2_nxt.cls = 6'd47; s2_nxt.has_m = 1'b1; s2_nxt.rs = RS_MODRM;
          s2_nxt.ik = opc[1] ? IK_SX : IK_ZX;
          s2_nxt.ilen = opc[1] ? 4'd1 : 4'd4;
        end else begin
          s2_nxt.ik = IK_CONST; s2_nxt.iconst = {8'h00, opc};
        end
      end
    endcase
  end

  // ---------------- stage 3: ModRM, SIB, displacement ----------------
  always_comb begin
    logic [5:0]  mpos, dpos, ipos, endp;
    logic [7:0]  m, sib;
    logic [1:0]  md;
    logic [2:0]  rg, rm;
    logic [2:0]  dlen;
    logic [3:0]  ilen;
    logic [31:0] draw;
    logic        has_sib;
    logic [3:0]  idx;
    mpos = {1'b0, s2b_r.pos} + {4'd0, s2_r.oplen};
    m    = byte_at(s2b_r.win, mpos);
    sib  = byte_at(s2b_r.win, mpos + 6'd1);
    md   = m[7:6];
    rg   = m[5:3];
    rm   = m[2:0];
    has_sib = (md != 2'd3) && (rm == 3'd4);
    idx  = {s2b_r.x, sib[5:3]};
    s3_nxt.win = s2b_r.win;
    s3_nxt.addr = s2b_r.addr;
    s3_nxt.cls = s2_r.cls;
    s3_nxt.var_code = s2_r.var_code;
    s3_nxt.osz = s2_r.osz;
    s3_nxt.regf = s2_r.regf;
    s3_nxt.ik = s2_r.ik;
    s3_nxt.br = s2_r.br;
    s3_nxt.iconst = s2_r.iconst;
    s3_nxt.rm_kind = 2'd3;
    s3_nxt.rm_base = 5'd0;
    s3_nxt.idx = 5'd16;
    s3_nxt.scale = 2'd0;
    dlen = 3'd0;
    ilen = s2_r.ilen;
    if (s2_r.has_m) begin
      // decode the r/m operand, register or memory form
      if (md == 2'd3) begin
        s3_nxt.rm_kind = 2'd0;
        s3_nxt.rm_base = regnum(rm, s2b_r.b, s2_r.mbf, s2b_r.rex);
      end else begin
        s3_nxt.rm_kind = 2'd1;
        if (has_sib) begin
          s3_nxt.scale = sib[7:6];
          s3_nxt.idx = (idx == 4'd4) ? 5'd16 : {1'b0, idx};
          if (sib[2:0] == 3'd5 && md == 2'd0) begin
            s3_nxt.rm_base = 5'd16; dlen = 3'd4;
          end else s3_nxt.rm_base = {1'b0, s2b_r.b, sib[2:0]};
        end else if (rm == 3'd5 && md == 2'd0) begin
          s3_nxt.rm_kind = 2'd2; dlen = 3'd4;
        end else s3_nxt.rm_base = {1'b0, s2b_r.b, rm};
        if (md == 2'd1) dlen = 3'd1;
        else if (md == 2'd2) dlen = 3'd4;
      end
      if (s2_r.rs == RS_MODRM) s3_nxt.regf = regnum(rg, s2b_r.r, s2_r.rbf, s2b_r.rex);
      if (s2_r.var_m) s3_nxt.var_code = {1'b0, rg};
      // resolve the groups selected by the reg field
      if (s2_r.grp == GRP_FEFF) begin
        if (rg == 3'd0 || rg == 3'd1) begin
          s3_nxt.cls = 6'd32 + {5'd0, rg[0]};
          if (s2_r.mbf) s3_nxt.osz = 2'd0;
        end else if (!s2_r.mbf && (rg == 3'd2 || rg == 3'd4 || rg == 3'd6)) begin
          // call, jmp and push r/m take consecutive classes
          s3_nxt.cls = 6'd33 + {4'd0, rg[2:1]}; s3_nxt.osz = 2'd3;
        end else begin
          s3_nxt.cls = 6'd0; s3_nxt.ik = IK_CONST; s3_nxt.iconst = {8'h00, s2_r.opc};
        end
      end else if (s2_r.grp == GRP_F6F7) begin
        if (rg == 3'd0) begin
          s3_nxt.cls = 6'd37; s3_nxt.ik = IK_ZX; ilen = s2_r.mbf ? 4'd1 : 4'd4;
        end else if (rg >= 3'd2 && rg <= 3'd5) begin
          s3_nxt.cls = 6'd36 + {3'd0, rg};
        end else begin
          s3_nxt.cls = 6'd0; s3_nxt.ik = IK_CONST; s3_nxt.iconst = {8'h00, s2_r.opc};
        end
      end
      dpos = mpos + 6'd1 + {5'd0, has_sib};
      ipos = dpos + {3'd0, dlen};
    end else begin
      dpos = mpos;
      ipos = mpos;
    end
    draw = {byte_at(s2b_r.win, dpos + 6'd3), byte_at(s2b_r.win, dpos + 6'd2),
            byte_at(s2b_r.win, dpos + 6'd1), byte_at(s2b_r.win, dpos)};
    if (dlen == 3'd1) s3_nxt.disp = {{24{draw[7]}}, draw[7:0]};
    else if (dlen == 3'd4) s3_nxt.disp = draw;
    else s3_nxt.disp = 32'd0;
    endp = ipos + {2'd0, ilen};
    s3_nxt.ipos = ipos;
    s3_nxt.ilen = ilen;
    s3_nxt.endp = endp[4:0];
    s3_nxt.ok = (endp <= {1'b0, s2b_r.cnt});
  end

  // ---------------- stage 4: immediate and branch target ----------------
  always_comb begin
    logic [63:0] raw, val;
    for (int j = 0; j < 8; j++) begin
      raw[j*8 +: 8] = byte_at(s3_r.win, s3_r.ipos + 6'(j));
    end
    case (s3_r.ilen)
      4'd1:    val = (s3_r.ik == IK_SX) ? {{56{raw[7]}}, raw[7:0]} : {56'd0, raw[7:0]};
      4'd2:    val = {48'd0, raw[15:0]};
      4'd4:    val = (s3_r.ik == IK_SX) ? {{32{raw[31]}}, raw[31:0]} : {32'd0, raw[31:0]};
      4'd8:    val = raw;
      default: val = 64'd0;
    endcase
    if (s3_r.ik == IK_ONE) val = 64'd1;
    else if (s3_r.ik == IK_CONST) val = {48'd0, s3_r.iconst};
    if (s3_r.br) val = s3_r.addr + {59'd0, s3_r.endp} + val;
    out_nxt.valid_res    = 1'b1;
    out_nxt.length       = s3_r.endp;
    out_nxt.form_class   = s3_r.cls;
    out_nxt.variant      = s3_r.var_code;
    out_nxt.operand_size = s3_r.osz;
    out_nxt.reg_field    = s3_r.regf;
    out_nxt.rm_kind      = s3_r.rm_kind;
    out_nxt.rm_base      = s3_r.rm_base;
    out_nxt.index_reg    = s3_r.idx;
    out_nxt.scale_log2   = s3_r.scale;
    out_nxt.displacement = s3_r.disp;
    out_nxt.immediate    = val;
    // drop every field when bytes ran out
    if (!s3_r.ok) out_nxt = '0;
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s2b_r <= s1_r;
    s3_r  <= s3_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/x86dec_checker.sv =====
`timescale 1ns / 1ps

module x86dec_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input x86dec_pkg::out_t  out_data
);

  // every transaction gives one result after the pipeline latency
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(x86dec_pkg::LATENCY) out_valid)
    else $error("missing result");

  // no result without a transaction
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##(x86dec_pkg::LATENCY) !out_valid)
    else $error("spurious result");

  // the decoder never holds off a transaction
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // a failed decode clears its length and immediate
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.valid_res) |-> (out_data.length == 5'd0 &&
      out_data.immediate == 64'd0))
    else $error("invalid result not cleared");

  // a good decode consumed at least one byte and at most the window
  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.valid_res) |-> (out_data.length != 5'd0 &&
      out_data.length <= 5'd16))
    else $error("bad length");

endmodule

bind x86_64_instruction_decoder x86dec_checker u_x86dec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== bench/x86_64_instruction_decoder_test.sv =====
`timescale 1ns / 1ps

module x86_64_instruction_decoder_test;

  // Form class codes
  localparam logic [5:0] FC_DB = 6'd0, FC_NOP = 6'd1, FC_INT3 = 6'd2, FC_RET = 6'd3,
    FC_LEAVE = 6'd4, FC_CWDE = 6'd5, FC_CDQ = 6'd6, FC_HLT = 6'd7, FC_INT = 6'd8,
    FC_SYSCALL = 6'd9, FC_RDTSC = 6'd10, FC_NOPRM = 6'd11, FC_JCC = 6'd12,
    FC_SETCC = 6'd13, FC_MOVZX = 6'd14, FC_MOVSX = 6'd15, FC_IMUL2 = 6'd16,
    FC_PUSH = 6'd17, FC_POP = 6'd18, FC_PUSHI = 6'd19, FC_JMP = 6'd20,
    FC_CALL = 6'd21, FC_RETI = 6'd22, FC_LEA = 6'd23, FC_MOVST = 6'd24,
    FC_MOVLD = 6'd25, FC_MOVSXD = 6'd26, FC_MOVRMI = 6'd27, FC_MOVRI = 6'd28,
    FC_ALUST = 6'd29, FC_ALULD = 6'd30, FC_ALUI = 6'd31, FC_INC = 6'd32,
    FC_CALLRM = 6'd34, FC_JMPRM = 6'd35, FC_PUSHRM = 6'd36, FC_TEST = 6'd37,
    FC_SHI = 6'd42, FC_SH1 = 6'd43, FC_SHCL = 6'd44, FC_XCHG = 6'd45,
    FC_XCHGA = 6'd46, FC_IMUL3 = 6'd47;
  localparam logic [1:0] RK_REG = 2'd0, RK_MEM = 2'd1, RK_RIP = 2'd2, RK_NONE = 2'd3;
  localparam logic [1:0] OS_8 = 2'd0, OS_32 = 2'd2, OS_64 = 2'd3;
  localparam logic [4:0] NO_INDEX = 5'd16;
  localparam int WIN = 16;

  // Decode scratch state for one window
  typedef struct {
    logic [7:0] b [16];
    int cnt, pos;
    bit ok, rex, w, r, x, bx;
    logic [2:0] modreg;
    logic [1:0] rmk, scl;
    logic [4:0] base, idx;
    logic [63:0] disp;
  } scan_t;

  function automatic logic [7:0] fetch_byte(ref scan_t s);
    if (s.pos >= s.cnt) begin
      s.ok = 0;
      return 8'h00;
    end
    s.pos++;
    return s.b[s.pos - 1];
  endfunction

  function automatic logic [63:0] fetch_le(ref scan_t s, input int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = fetch_byte(s);
    return v;
  endfunction

  function automatic logic [63:0] sext8(logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sext32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [4:0] reg_num(scan_t s, logic [2:0] x3, bit ext, bit bytef);
    if (bytef && !s.rex && x3 >= 4) return 5'd12 + x3;
    return {1'b0, ext, x3};
  endfunction

  // Decode ModRM, SIB and displacement
  function automatic void scan_modrm(ref scan_t s, input bit bytef);
    logic [7:0] m, sib;
    logic [3:0] ix;
    m = fetch_byte(s);
    s.modreg = m[5:3];
    s.idx = NO_INDEX;
    s.scl = 0;
    s.disp = 0;
    if (m[7:6] == 2'd3) begin
      s.rmk = RK_REG;
      s.base = reg_num(s, m[2:0], s.bx, bytef);
      return;
    end
    s.rmk = RK_MEM;
    if (m[2:0] == 3'd4) begin
      sib = fetch_byte(s);
      ix = {s.x, sib[5:3]};
      s.scl = sib[7:6];
      s.idx = (ix == 4'd4) ? NO_INDEX : {1'b0, ix};
      if (sib[2:0] == 3'd5 && m[7:6] == 2'd0) begin
        s.base = 5'd16;
        s.disp = sext32(fetch_le(s, 4));
        return;
      end
      s.base = {1'b0, s.bx, sib[2:0]};
    end else if (m[2:0] == 3'd5 && m[7:6] == 2'd0) begin
      s.rmk = RK_RIP;
      s.base = 0;
      s.disp = sext32(fetch_le(s, 4));
      return;
    end else begin
      s.base = {1'b0, s.bx, m[2:0]};
    end
    if (m[7:6] == 2'd1) s.disp = sext8(fetch_byte(s));
    else if (m[7:6] == 2'd2) s.disp = sext32(fetch_le(s, 4));
  endfunction

  // Work out the decoded instruction for one window
  function automatic x86dec_pkg::out_t decode_insn(x86dec_pkg::in_t t);
    scan_t s;
    logic [7:0] opc, k, p;
    logic [5:0] cls;
    logic [3:0] var_c;
    logic [1:0] osz;
    logic [4:0] regf;
    logic [63:0] imm, rel;
    bit br, bf;
    x86dec_pkg::out_t o;
    for (int i = 0; i < 8; i++) begin
      s.b[i] = t.bytes_low[8*i +: 8];
      s.b[i+8] = t.bytes_high[8*i +: 8];
    end
    s.cnt = (t.avail_count > WIN) ? WIN : int'(t.avail_count);
    s.pos = 0; s.ok = 1;
    s.rex = 0; s.w = 0; s.r = 0; s.x = 0; s.bx = 0;
    s.modreg = 0; s.rmk = RK_NONE; s.base = 0; s.idx = NO_INDEX; s.scl = 0; s.disp = 0;
    cls = FC_DB; var_c = 0; regf = 0; imm = 0; rel = 0; br = 0;
    // scan prefixes
    while (s.pos < s.cnt) begin
      p = s.b[s.pos];
      if (p >= 8'h40 && p <= 8'h4F) begin
        s.rex = 1; s.w = p[3]; s.r = p[2]; s.x = p[1]; s.bx = p[0];
      end else if (p == 8'h66 || p == 8'h67 || p == 8'hF2 || p == 8'hF3) begin
        s.rex = 0; s.w = 0; s.r = 0; s.x = 0; s.bx = 0;
      end else break;
      s.pos++;
    end
    osz = s.w ? OS_64 : OS_32;
    opc = fetch_byte(s);
    case (opc)
      8'h90: if (s.bx) begin cls = FC_XCHGA; regf = 5'd8; end else cls = FC_NOP;
      8'hCC: cls = FC_INT3;
      8'hC3: begin cls = FC_RET; osz = OS_64; end
      8'hC9: begin cls = FC_LEAVE; osz = OS_64; end
      8'h98: cls = FC_CWDE;
      8'h99: cls = FC_CDQ;
      8'hF4: cls = FC_HLT;
      8'hCD: begin cls = FC_INT; imm = fetch_le(s, 1); end
      8'hC2: begin cls = FC_RETI; osz = OS_64; imm = fetch_le(s, 2); end
      8'h68: begin cls = FC_PUSHI; osz = OS_64; imm = fetch_le(s, 4); end
      8'h6A: begin cls = FC_PUSHI; osz = OS_64; imm = sext8(fetch_byte(s)); end
      8'hEB: begin cls = FC_JMP; osz = OS_64; br = 1; rel = sext8(fetch_byte(s)); end
      8'hE9: begin cls = FC_JMP; osz = OS_64; br = 1; rel = sext32(fetch_le(s, 4)); end
      8'hE8: begin cls = FC_CALL; osz = OS_64; br = 1; rel = sext32(fetch_le(s, 4)); end
      8'h8D: begin cls = FC_LEA; scan_modrm(s, 0); regf = reg_num(s, s.modreg, s.r, 0); end
      8'h63: begin
        cls = FC_MOVSXD; osz = OS_64; scan_modrm(s, 0);
        regf = reg_num(s, s.modreg, s.r, 0);
      end
      8'hC6: begin cls = FC_MOVRMI; osz = OS_8; scan_modrm(s, 1); imm = fetch_le(s, 1); end
      8'hC7: begin cls = FC_MOVRMI; scan_modrm(s, 0); imm = fetch_le(s, 4); end
      8'h0F: begin
        k = fetch_byte(s);
        if (k == 8'h05) cls = FC_SYSCALL;
        else if (k == 8'h31) cls = FC_RDTSC;
        else if (k == 8'h1F) begin cls = FC_NOPRM; scan_modrm(s, 0); end
        else if (k >= 8'h80 && k <= 8'h8F) begin
          cls = FC_JCC; var_c = k[3:0]; osz = OS_64; br = 1; rel = sext32(fetch_le(s, 4));
        end else if (k >= 8'h90 && k <= 8'h9F) begin
          cls = FC_SETCC; var_c = k[3:0]; osz = OS_8; scan_modrm(s, 1);
        end else if (k == 8'hB6 || k == 8'hB7 || k == 8'hBE || k == 8'hBF) begin
          cls = (k >= 8'hBE) ? FC_MOVSX : FC_MOVZX; var_c = {3'd0, k[0]};
          scan_modrm(s, !k[0]); regf = reg_num(s, s.modreg, s.r, 0);
        end else if (k == 8'hAF) begin
          cls = FC_IMUL2; scan_modrm(s, 0); regf = reg_num(s, s.modreg, s.r, 0);
        end else begin
          cls = FC_DB; imm = {48'd0, 8'h0F, k};
        end
      end
      default: begin
        if (opc >= 8'h50 && opc <= 8'h5F) begin
          cls = (opc < 8'h58) ? FC_PUSH : FC_POP; osz = OS_64;
          regf = reg_num(s, opc[2:0], s.bx, 0);
        end else if (opc >= 8'h70 && opc <= 8'h7F) begin
          cls = FC_JCC; var_c = opc[3:0]; osz = OS_64; br = 1; rel = sext8(fetch_byte(s));
        end else if (opc >= 8'h88 && opc <= 8'h8B) begin
          bf = !opc[0]; cls = opc[1] ? FC_MOVLD : FC_MOVST; if (bf) osz = OS_8;
          scan_modrm(s, bf); regf = reg_num(s, s.modreg, s.r, bf);
        end else if (opc >= 8'hB0 && opc <= 8'hBF) begin
          bf = opc <= 8'hB7; cls = FC_MOVRI; regf = reg_num(s, opc[2:0], s.bx, bf);
          if (bf) begin osz = OS_8; imm = fetch_le(s, 1); end
          else imm = fetch_le(s, s.w ? 8 : 4);
        end else if (opc < 8'h40 && opc[2:0] < 3'd4) begin
          bf = !opc[0]; cls = opc[1] ? FC_ALULD : FC_ALUST; var_c = {1'b0, opc[5:3]};
          if (bf) osz = OS_8;
          scan_modrm(s, bf); regf = reg_num(s, s.modreg, s.r, bf);
        end else if (opc == 8'h80 || opc == 8'h81 || opc == 8'h83) begin
          bf = opc == 8'h80; cls = FC_ALUI; if (bf) osz = OS_8;
          scan_modrm(s, bf); var_c = {1'b0, s.modreg};
          if (bf) imm = fetch_le(s, 1);
          else if (opc == 8'h83) imm = sext8(fetch_byte(s));
          else imm = fetch_le(s, 4);
        end else if (opc == 8'hFE || opc == 8'hFF) begin
          bf = opc == 8'hFE; scan_modrm(s, bf); var_c = {1'b0, s.modreg};
          if (s.modreg <= 1) begin
            cls = FC_INC + s.modreg; if (bf) osz = OS_8;
          end else if (!bf && (s.modreg == 2 || s.modreg == 4 || s.modreg == 6)) begin
            cls = (s.modreg == 2) ? FC_CALLRM : (s.modreg == 4) ? FC_JMPRM : FC_PUSHRM;
            osz = OS_64;
          end else begin cls = FC_DB; imm = {56'd0, opc}; end
        end else if (opc == 8'hF6 || opc == 8'hF7) begin
          bf = opc == 8'hF6; if (bf) osz = OS_8;
          scan_modrm(s, bf); var_c = {1'b0, s.modreg};
          if (s.modreg == 0) begin cls = FC_TEST; imm = fetch_le(s, bf ? 1 : 4); end
          else if (s.modreg >= 2 && s.modreg <= 5) cls = 6'd36 + s.modreg;
          else begin cls = FC_DB; imm = {56'd0, opc}; end
        end else if (opc == 8'hC0 || opc == 8'hC1 || (opc >= 8'hD0 && opc <= 8'hD3)) begin
          bf = !opc[0]; if (bf) osz = OS_8;
          scan_modrm(s, bf); var_c = {1'b0, s.modreg};
          if (opc <= 8'hC1) begin cls = FC_SHI; imm = fetch_le(s, 1); end
          else if (opc <= 8'hD1) begin cls = FC_SH1; imm = 64'd1; end
          else cls = FC_SHCL;
        end else if (opc == 8'h86 || opc == 8'h87) begin
          bf = opc == 8'h86; cls = FC_XCHG; if (bf) osz = OS_8;
          scan_modrm(s, bf); regf = reg_num(s, s.modreg, s.r, bf);
        end else if (opc >= 8'h91 && opc <= 8'h97) begin
          cls = FC_XCHGA; regf = reg_num(s, opc[2:0], s.bx, 0);
        end else if (opc == 8'h69 || opc == 8'h6B) begin
          cls = FC_IMUL3; scan_modrm(s, 0); regf = reg_num(s, s.modreg, s.r, 0);
          imm = (opc == 8'h6B) ? sext8(fetch_byte(s)) : fetch_le(s, 4);
        end else begin
          cls = FC_DB; imm = {56'd0, opc};
        end
      end
    endcase
    o = '0;
    if (!s.ok) return o;
    if (br) imm = t.insn_address + 64'(s.pos) + rel;
    o.valid_res = 1;
    o.length = s.pos[4:0];
    o.form_class = cls;
    o.variant = var_c;
    o.operand_size = osz;
    o.reg_field = regf;
    o.rm_kind = s.rmk;
    o.rm_base = s.base;
    o.index_reg = s.idx;
    o.scale_log2 = s.scl;
    o.displacement = s.disp[31:0];
    o.immediate = imm;
    return o;
  endfunction

  // Scoreboard of decoded instructions still awaited
  class decode_scoreboard;
    x86dec_pkg::out_t pending[$];
    int mismatches, checked, invalid_seen;

    function void note_window(x86dec_pkg::in_t t);
      pending.push_back(decode_insn(t));
    endfunction

    function void check_result(x86dec_pkg::out_t got);
      x86dec_pkg::out_t exp_o;
      if (pending.size() == 0) begin
        report(got, got, "unexpected result");
        return;
      end
      exp_o = pending.pop_front();
      checked++;
      if (!got.valid_res) invalid_seen++;
      if (got !== exp_o) report(exp_o, got, "field mismatch");
    endfunction

    function void report(x86dec_pkg::out_t e, x86dec_pkg::out_t g, string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: exp v%0d len%0d fc%0d var%0d os%0d reg%0d rk%0d base%0d idx%0d",
          what, e.valid_res, e.length, e.form_class, e.variant, e.operand_size,
          e.reg_field, e.rm_kind, e.rm_base, e.index_reg);
        $display("  exp sc%0d d%h i%h", e.scale_log2, e.displacement, e.immediate);
        $display("  got v%0d len%0d fc%0d var%0d os%0d reg%0d rk%0d base%0d idx%0d",
          g.valid_res, g.length, g.form_class, g.variant, g.operand_size,
          g.reg_field, g.rm_kind, g.rm_base, g.index_reg);
        $display("  got sc%0d d%h i%h", g.scale_log2, g.displacement, g.immediate);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid;
  x86dec_pkg::in_t in_data = '0;
  x86dec_pkg::out_t out_data;
  decode_scoreboard sb;
  int sent;

  x86_64_instruction_decoder u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Note accepted transactions and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_window(in_data);
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // Drive one window, wait for acceptance, then drop start and idle if gap is nonzero
  task automatic send_window(logic [7:0] bts [16], int cnt, logic [63:0] addr, int gap);
    x86dec_pkg::in_t t;
    for (int i = 0; i < 8; i++) begin
      t.bytes_low[8*i +: 8] = bts[i];
      t.bytes_high[8*i +: 8] = bts[i+8];
    end
    t.avail_count = 5'(cnt);
    t.insn_address = addr;
    @(negedge clk);
    in_data <= t;
    start <= 1;
    do @(posedge clk); while (busy);
    sent++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] tbl [48] = '{8'h90, 8'hCC, 8'hC3, 8'hC9, 8'h98, 8'h99, 8'hF4, 8'hCD,
      8'hC2, 8'h68, 8'h6A, 8'hEB, 8'hE9, 8'hE8, 8'h8D, 8'h63, 8'hC6, 8'hC7, 8'h0F,
      8'h50, 8'h5B, 8'h74, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'hB0, 8'hBC, 8'h01, 8'h2B,
      8'h80, 8'h81, 8'h83, 8'h82, 8'hFE, 8'hFF, 8'hF6, 8'hF7, 8'hC0, 8'hC1, 8'hD0,
      8'hD3, 8'h86, 8'h87, 8'h95, 8'h69, 8'h6B, 8'h0F};
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return tbl[$urandom_range(0, 47)];
  endfunction

  function automatic logic [7:0] pick_second();
    logic [7:0] tbl [10] = '{8'h05, 8'h31, 8'h1F, 8'h84, 8'h9F, 8'hB6, 8'hB7, 8'hBE,
      8'hBF, 8'hAF};
    if ($urandom_range(0, 5) == 0) return 8'($urandom);
    if ($urandom_range(0, 1) == 0) return 8'h80 + 8'($urandom_range(0, 31));
    return tbl[$urandom_range(0, 9)];
  endfunction

  // Build a random but mostly well-formed instruction window
  task automatic random_window(output logic [7:0] bts [16], output int cnt);
    int npre, p;
    logic [7:0] pre [6] = '{8'h66, 8'h67, 8'hF2, 8'hF3, 8'h48, 8'h4F};
    for (int i = 0; i < 16; i++) bts[i] = 8'($urandom);
    npre = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0;
    p = 0;
    for (int i = 0; i < npre; i++) begin
      bts[p] = $urandom_range(0, 1) ? 8'h40 + 8'($urandom_range(0, 15))
                                    : pre[$urandom_range(0, 5)];
      p++;
    end
    if ($urandom_range(0, 2) == 0) bts[p] = 8'h40 + 8'($urandom_range(0, 15));
    else bts[p] = pick_opcode();
    if (bts[p] >= 8'h40 && bts[p] <= 8'h4F) p++;
    if (p < 16) bts[p] = pick_opcode();
    if (p < 15 && bts[p] == 8'h0F) bts[p+1] = pick_second();
    case ($urandom_range(0, 9))
      0: cnt = $urandom_range(0, 31);
      1, 2: cnt = $urandom_range(0, 16);
      default: cnt = 16;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [7:0] bts [16];
    int cnt, gap;
    logic [7:0] dir [22][16] = '{
      '{default: 8'h00},
      '{default: 8'hFF},
      '{0: 8'h48, 1: 8'h8B, 2: 8'h84, 3: 8'hC8, 4: 8'h78, 5: 8'h56, 6: 8'h34,
        7: 8'h92, default: 8'h00},
      '{0: 8'h4C, 1: 8'h8D, 2: 8'h05, 3: 8'h00, 4: 8'h00, 5: 8'h00, 6: 8'h80,
        default: 8'h00},
      '{0: 8'h41, 1: 8'h55, default: 8'h00},
      '{0: 8'h41, 1: 8'h90, default: 8'h00},
      '{0: 8'h48, 1: 8'h66, 2: 8'h89, 3: 8'hE5, default: 8'h00},
      '{0: 8'h40, 1: 8'h48, 2: 8'h88, 3: 8'hE0, default: 8'h00},
      '{0: 8'h88, 1: 8'hE0, default: 8'h00},
      '{0: 8'h82, 1: 8'h00, default: 8'h00},
      '{0: 8'h0F, 1: 8'h8F, 2: 8'hFF, 3: 8'hFF, 4: 8'hFF, 5: 8'hFF, default: 8'h00},
      '{0: 8'h0F, 1: 8'h0B, default: 8'h00},
      '{0: 8'hFE, 1: 8'h54, 2: 8'h24, 3: 8'h80, default: 8'h00},
      '{0: 8'hF7, 1: 8'h3C, 2: 8'h25, 3: 8'h01, 4: 8'h02, 5: 8'h03, 6: 8'h04,
        default: 8'h00},
      '{0: 8'h83, 1: 8'hC0, 2: 8'hFF, default: 8'h00},
      '{0: 8'h48, 1: 8'hB8, 2: 8'h01, 3: 8'h23, 4: 8'h45, 5: 8'h67, 6: 8'h89,
        7: 8'hAB, 8: 8'hCD, 9: 8'hEF, default: 8'h00},
      '{0: 8'hE8, 1: 8'hFB, 2: 8'hFF, 3: 8'hFF, 4: 8'hFF, default: 8'h00},
      '{0: 8'h7F, 1: 8'h80, default: 8'h00},
      '{8'h66, 8'h67, 8'hF2, 8'hF3, 8'h66, 8'h67, 8'hF2, 8'hF3, 8'h66, 8'h67,
        8'hF2, 8'hF3, 8'h66, 8'h67, 8'hF2, 8'hF3},
      '{0: 8'hD1, 1: 8'hE0, default: 8'h00},
      '{0: 8'h6B, 1: 8'hC1, 2: 8'h80, default: 8'h00},
      '{0: 8'hC2, 1: 8'hFF, 2: 8'hFF, default: 8'h00}};
    sb = new();
    sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed windows, full and truncated
    for (int i = 0; i < 22; i++) begin
      bts = dir[i];
      send_window(bts, (i == 1) ? 31 : (i == 13) ? 6 : 16,
                  (i % 2) ? 64'hFFFF_FFFF_FFFF_FFF0 : 64'h0, 0);
    end
    bts = dir[2];
    send_window(bts, 0, 64'h0, 0);
    bts = dir[15];
    send_window(bts, 9, 64'h0, 3);
    // random windows with random gaps
    for (int n = 0; n < 2000; n++) begin
      random_window(bts, cnt);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      if (n >= 1000 && n < 1200) gap = 0;
      send_window(bts, cnt, rand64(), gap);
      if (n == 500) begin
        @(negedge clk);
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
    end
    @(negedge clk);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (x86dec_pkg::LATENCY + 4) @(posedge clk);
    $display("Decoded %0d windows, %0d results checked, %0d ran out of bytes.",
             sent, sb.checked, sb.invalid_seen);
    if (sb.mismatches == 0) $display("x86_64_instruction_decoder: match");
    else $display("x86_64_instruction_decoder: mismatch");
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("x86_64_instruction_decoder: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/x86dec_pkg.sv
hdl/x86_64_instruction_decoder.sv
hdl/x86dec_checker.sv
bench/x86_64_instruction_decoder_test.sv
